[hdl/b92_pkg.sv]
package b92_pkg;

  localparam int unsigned HOP_CHARS_DEF = 4;
  localparam int unsigned QUEUE_DEPTH   = 8;

  localparam logic [7:0] COLON_BYTE = 8'd58;
  localparam logic [7:0] MID_TOP    = 8'd127;
  localparam logic [7:0] OFS_LOW    = 8'd33;
  localparam logic [7:0] OFS_MID    = 8'd34;
  localparam logic [7:0] CHAR_T     = 8'h54;

  // floor(x / 10000) == (x * MEAN_MAGIC) >> MEAN_SHIFT for every 32-bit x
  localparam logic [31:0] MEAN_MAGIC = 32'd3518437209;
  localparam int unsigned MEAN_SHIFT = 45;

  typedef enum logic [3:0] {
    KIND_HASH        = 4'd0,
    KIND_PATH        = 4'd1,
    KIND_PATH_LEN    = 4'd2,
    KIND_PREFIX_CNT  = 4'd3,
    KIND_LAST_CHANGE = 4'd4,
    KIND_MEAN_UP     = 4'd5,
    KIND_MEAN_DOWN   = 4'd6,
    KIND_COLLECTOR   = 4'd7,
    KIND_ACTIVE      = 4'd8,
    KIND_PAST        = 4'd9,
    KIND_END         = 4'd15
  } field_kind_t;

  typedef enum logic [1:0] {
    FLAG_EMPTY,
    FLAG_T,
    FLAG_OTHER
  } flag_t;

  typedef struct packed {
    logic        valid;
    field_kind_t kind;
    logic [31:0] value;
    logic        div;
    logic        done;
  } raw_res_t;

endpackage

[hdl/b92_ifs.sv]
interface b92_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_byte;
  logic       end_of_record;

  modport source (output valid, output char_byte, output end_of_record, input ready);
  modport sink (input valid, input char_byte, input end_of_record, output ready);
endinterface

interface b92_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  field_kind;
  logic [31:0] field_value;
  logic        record_done;

  modport source (output valid, output field_kind, output field_value, output record_done,
                  input ready);
  modport sink (input valid, input field_kind, input field_value, input record_done,
                output ready);
endinterface

[hdl/b92_field_dec.sv]
module b92_field_dec
  import b92_pkg::*;
#(
  parameter int unsigned HopChars = HOP_CHARS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       accept,
  input  logic [7:0] char_byte,
  input  logic       end_of_record,
  output raw_res_t   res0_r,
  output raw_res_t   res1_r
);

  localparam int unsigned CntW  = (HopChars > 2) ? 2 : 1;
  localparam int unsigned CntW1 = CntW + 1;
  localparam logic [CntW1-1:0] HopLast = CntW1'(HopChars);

  logic [31:0]     acc_r, acc_nxt;
  logic [31:0]     wgt_r, wgt_nxt;
  field_kind_t     fn_r, fn_nxt;
  logic [CntW-1:0] hop_r, hop_nxt;
  flag_t           flag_r, flag_nxt;

  logic             is_colon;
  logic             in_rng;
  logic [7:0]       digit;
  logic [31:0]      acc_add;
  logic [31:0]      wgt_mul;
  logic [CntW1-1:0] hop_inc;
  logic             hop_emit;
  raw_res_t         byte_res;
  raw_res_t         end_res;
  raw_res_t         r0, r1;

  function automatic raw_res_t close_res(field_kind_t k, logic [31:0] a, logic hop_nz,
                                         flag_t f);
    raw_res_t r;
    r       = '0;
    r.kind  = k;
    r.value = a;
    r.valid = (k < KIND_PAST) && !((k == KIND_PATH) && !hop_nz);
    r.div   = (k == KIND_MEAN_UP) || (k == KIND_MEAN_DOWN);
    if (k == KIND_ACTIVE) begin
      r.value = {31'b0, f == FLAG_T};
    end
    return r;
  endfunction

  assign is_colon = (char_byte == COLON_BYTE);
  assign in_rng   = (fn_r < KIND_PAST);
  assign digit    = ((char_byte < COLON_BYTE) || (char_byte > MID_TOP)) ?
                    8'(char_byte - OFS_LOW) : 8'(char_byte - OFS_MID);
  assign acc_add  = acc_r + 32'({24'b0, digit} * wgt_r);
  // weight * 92 as shift-add: 92 = 64 + 16 + 8 + 4
  assign wgt_mul  = (wgt_r << 6) + (wgt_r << 4) + (wgt_r << 3) + (wgt_r << 2);
  assign hop_inc  = {1'b0, hop_r} + CntW1'(1);
  assign hop_emit = (hop_inc >= HopLast);

  always_comb begin
    acc_nxt  = acc_r;
    wgt_nxt  = wgt_r;
    fn_nxt   = fn_r;
    hop_nxt  = hop_r;
    flag_nxt = flag_r;
    byte_res = '0;
    if (is_colon) begin
      if (in_rng) begin
        byte_res = close_res(fn_r, acc_r, hop_r != '0, flag_r);
        acc_nxt  = '0;
        wgt_nxt  = 32'd1;
        hop_nxt  = '0;
        flag_nxt = FLAG_EMPTY;
        fn_nxt   = field_kind_t'(fn_r + 4'd1);
      end
    end else if (in_rng) begin
      if (fn_r == KIND_ACTIVE) begin
        flag_nxt = ((flag_r == FLAG_EMPTY) && (char_byte == CHAR_T)) ? FLAG_T : FLAG_OTHER;
      end
      acc_nxt = acc_add;
      wgt_nxt = wgt_mul;
      if (fn_r == KIND_PATH) begin
        if (hop_emit) begin
          byte_res.valid = 1'b1;
          byte_res.kind  = KIND_PATH;
          byte_res.value = acc_add;
          acc_nxt        = '0;
          wgt_nxt        = 32'd1;
          hop_nxt        = '0;
        end else begin
          hop_nxt = hop_inc[CntW-1:0];
        end
      end
    end
  end

  // record end closes whatever field the byte left open
  assign end_res = close_res(fn_nxt, acc_nxt, hop_nxt != '0, flag_nxt);

  always_comb begin
    r0 = byte_res;
    r1 = '0;
    if (end_of_record) begin
      if (byte_res.valid) begin
        if (end_res.valid) begin
          // field just opened by the colon is empty, so its value is zero
          r1      = end_res;
          r1.done = 1'b1;
        end else begin
          r0.done = 1'b1;
        end
      end else if (end_res.valid) begin
        r0      = end_res;
        r0.done = 1'b1;
      end else begin
        r0       = '0;
        r0.valid = 1'b1;
        r0.kind  = KIND_END;
        r0.done  = 1'b1;
      end
    end
    // drop beats from a byte that was not taken
    r0.valid = r0.valid && accept;
    r1.valid = r1.valid && accept;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r  <= '0;
      wgt_r  <= 32'd1;
      fn_r   <= KIND_HASH;
      hop_r  <= '0;
      flag_r <= FLAG_EMPTY;
      res0_r <= '0;
      res1_r <= '0;
    end else begin
      res0_r <= r0;
      res1_r <= r1;
      if (accept) begin
        if (end_of_record) begin
          acc_r  <= '0;
          wgt_r  <= 32'd1;
          fn_r   <= KIND_HASH;
          hop_r  <= '0;
          flag_r <= FLAG_EMPTY;
        end else begin
          acc_r  <= acc_nxt;
          wgt_r  <= wgt_nxt;
          fn_r   <= fn_nxt;
          hop_r  <= hop_nxt;
          flag_r <= flag_nxt;
        end
      end
    end
  end

endmodule

[hdl/b92_res_queue.sv]
module b92_res_queue
  import b92_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  raw_res_t  res0,
  input  raw_res_t  res1,
  output logic      room,
  b92_out_if.source out_ch
);

  localparam int unsigned PtrW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CntW = PtrW + 1;

  logic [3:0]  kind_r  [QUEUE_DEPTH];
  logic [31:0] value_r [QUEUE_DEPTH];
  logic        done_r  [QUEUE_DEPTH];

  logic [PtrW-1:0] wptr_r, wptr_nxt;
  logic [PtrW-1:0] rptr_r, rptr_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;

  logic [63:0]     prod;
  logic [31:0]     val0;
  logic [CntW-1:0] wr_n;
  logic            pop;
  logic [CntW-1:0] pend;
  logic [PtrW-1:0] wptr_p1;

  assign prod    = {32'b0, res0.value} * {32'b0, MEAN_MAGIC};
  assign val0    = res0.div ? 32'(prod[63:MEAN_SHIFT]) : res0.value;
  assign wr_n    = CntW'(res0.valid) + CntW'(res1.valid);
  assign pop     = out_ch.valid && out_ch.ready;
  assign wptr_p1 = wptr_r + PtrW'(1);

  assign wptr_nxt = wptr_r + PtrW'(wr_n);
  assign rptr_nxt = rptr_r + PtrW'(pop);
  assign cnt_nxt  = cnt_r + wr_n - CntW'(pop);

  // leave space for two beats from the next byte
  assign pend = cnt_r + wr_n;
  assign room = (pend <= CntW'(QUEUE_DEPTH - 2));

  assign out_ch.valid       = (cnt_r != '0);
  assign out_ch.field_kind  = kind_r[rptr_r];
  assign out_ch.field_value = value_r[rptr_r];
  assign out_ch.record_done = done_r[rptr_r];

  always_ff @(posedge clk) begin
    if (res0.valid) begin
      kind_r[wptr_r]  <= res0.kind;
      value_r[wptr_r] <= val0;
      done_r[wptr_r]  <= res0.done;
    end
    if (res1.valid) begin
      kind_r[wptr_p1]  <= res1.kind;
      value_r[wptr_p1] <= res1.value;
      done_r[wptr_p1]  <= res1.done;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

endmodule

[hdl/base92_record_field_decoder_core.sv]
// Base-92 record field decoder. Takes one byte of a colon-separated record per
// beat and returns each field as it closes: hash, path hops (one per HopChars
// characters plus any partial hop), path length, prefix count, last change,
// mean up and mean down (divided by 10000), collector and the active flag.
// A byte is accepted every cycle while the queue has room for two more beats;
// one byte gives up to two result beats, which leave one per cycle, while the
// sink is ready, through an eight-entry result queue, so a stream that averages
// more than one result per byte is held back by the output side. The first
// result of a byte is registered in the result register behind the digit
// accumulator and then in the queue, which is written through the mean divider;
// a second result from the same byte leaves the queue after it.
module base92_record_field_decoder_core
  import b92_pkg::*;
#(
  parameter int unsigned HopChars = HOP_CHARS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  b92_in_if.sink    in_ch,
  b92_out_if.source out_ch
);

  raw_res_t res0;
  raw_res_t res1;
  logic     room;
  logic     accept;

  assign in_ch.ready = room;
  assign accept      = in_ch.valid && room;

  b92_field_dec #(
    .HopChars (HopChars)
  ) u_field_dec (
    .clk           (clk),
    .rst_n         (rst_n),
    .accept        (accept),
    .char_byte     (in_ch.char_byte),
    .end_of_record (in_ch.end_of_record),
    .res0_r        (res0),
    .res1_r        (res1)
  );

  b92_res_queue u_res_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .res0   (res0),
    .res1   (res1),
    .room   (room),
    .out_ch (out_ch)
  );

endmodule

[bench/base92_record_field_decoder_core_test.sv]
module base92_record_field_decoder_core_test
  import b92_pkg::*;
();

  localparam int unsigned FIELD_COUNT    = 9;
  localparam logic [31:0] MEAN_DIV       = 32'd10000;
  localparam logic [31:0] DIGIT_BASE     = 32'd92;
  localparam int unsigned ITEM_TARGET    = 1400;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned TAIL_CYCLES    = 10;

  typedef struct packed {
    field_kind_t kind;
    logic [31:0] value;
    logic        done;
  } field_result_t;

  typedef struct packed {
    logic [7:0] char_byte;
    logic       eor;
    logic       hold;
  } text_beat_t;

  logic clk = 1'b0;
  logic rst_n;

  b92_in_if  in_ch ();
  b92_out_if out_ch ();

  base92_record_field_decoder_core u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #4 clk = ~clk;

  text_beat_t    pending_bytes[$];
  field_result_t expected_fields[$];
  int unsigned   fail_count  = 0;
  int unsigned   idle_cycles = 0;
  logic          in_fired    = 1'b0;

  // decoder state as predicted
  logic [31:0] tally;
  logic [31:0] place_weight;
  logic [3:0]  field_idx;
  logic [1:0]  hop_fill;
  flag_t       flag_state;

  task automatic clear_field();
    tally        = 32'd0;
    place_weight = 32'd1;
    hop_fill     = 2'd0;
    flag_state   = FLAG_EMPTY;
  endtask

  task automatic clear_record();
    clear_field();
    field_idx = 4'd0;
  endtask

  // result of closing the open field; returns 0 when the field gives none
  function automatic bit close_result(output field_result_t r);
    r = '{field_kind_t'(field_idx), tally, 1'b0};
    case (field_kind_t'(field_idx))
      KIND_PATH: begin
        return hop_fill != 2'd0;
      end
      KIND_MEAN_UP, KIND_MEAN_DOWN: begin
        r.value = tally / MEAN_DIV;
      end
      KIND_ACTIVE: begin
        r.value = {31'd0, flag_state == FLAG_T};
      end
      default: begin
      end
    endcase
    return 1'b1;
  endfunction

  task automatic decode_byte(input logic [7:0] b, input logic eor);
    field_result_t step_res [0:2];
    field_result_t r;
    int            n;
    logic [7:0]    digit;
    n = 0;
    if (b == COLON_BYTE) begin
      if (field_idx < FIELD_COUNT) begin
        if (close_result(r)) begin
          step_res[n] = r;
          n++;
        end
        clear_field();
        field_idx++;
      end
    end else if (field_idx < FIELD_COUNT) begin
      if (field_idx == KIND_ACTIVE) begin
        flag_state = (flag_state == FLAG_EMPTY && b == CHAR_T) ? FLAG_T : FLAG_OTHER;
      end
      digit = (b < COLON_BYTE || b > MID_TOP) ? b - OFS_LOW : b - OFS_MID;
      tally = tally + {24'd0, digit} * place_weight;
      place_weight = place_weight * DIGIT_BASE;
      if (field_idx == KIND_PATH) begin
        if (hop_fill + 1 >= HOP_CHARS_DEF) begin
          step_res[n] = '{KIND_PATH, tally, 1'b0};
          n++;
          tally        = 32'd0;
          place_weight = 32'd1;
          hop_fill     = 2'd0;
        end else begin
          hop_fill++;
        end
      end
    end
    if (eor) begin
      if (field_idx < FIELD_COUNT && close_result(r)) begin
        step_res[n] = r;
        n++;
      end
      // nothing else to carry the record end: send the bare marker
      if (n == 0) begin
        step_res[n] = '{KIND_END, 32'd0, 1'b0};
        n++;
      end
      step_res[n-1].done = 1'b1;
      clear_record();
    end
    for (int i = 0; i < n; i++) expected_fields = {expected_fields, step_res[i]};
  endtask

  function automatic int unsigned gap_len(input bit calm);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [7:0] digit_char();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (b == COLON_BYTE);
    return b;
  endfunction

  task automatic queue_byte(input logic [7:0] b, input logic eor, input logic hold);
    text_beat_t beat;
    beat          = '{b, eor, hold};
    pending_bytes = {pending_bytes, beat};
  endtask

  task automatic queue_record(input int unsigned nf, input logic hold);
    logic [7:0]  text[$];
    int unsigned len;
    int unsigned r;
    for (int unsigned f = 0; f < nf; f++) begin
      if (f > 0) text = {text, COLON_BYTE};
      r = $urandom_range(0, 99);
      if (f == KIND_ACTIVE) begin
        if (r < 45) begin
          text = {text, CHAR_T};
        end else if (r < 75) begin
          if (r < 60) len = 0;
          else begin
            text = {text, CHAR_T};
            len = $urandom_range(1, 2);
          end
          for (int unsigned i = 0; i < len; i++) text = {text, digit_char()};
        end else begin
          len = $urandom_range(1, 3);
          for (int unsigned i = 0; i < len; i++) text = {text, digit_char()};
        end
      end else begin
        if (f == KIND_PATH) len = (r < 75) ? $urandom_range(0, 9) : $urandom_range(10, 16);
        else len = (r < 10) ? 0 : $urandom_range(1, 6);
        for (int unsigned i = 0; i < len; i++) text = {text, digit_char()};
      end
    end
    if (text.size() == 0) text = {text, digit_char()};
    foreach (text[i]) queue_byte(text[i], i == text.size() - 1, hold && i == 0);
  endtask

  // driver: present the next byte once the last one has gone
  int unsigned in_gap_left = 0;
  bit          in_calm     = 1'b0;
  text_beat_t  next_beat;

  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_fired) begin
      if ($urandom_range(0, 149) == 0) in_calm = !in_calm;
      if (in_gap_left != 0) begin
        in_ch.valid <= 1'b0;
        in_gap_left--;
      end else if (pending_bytes.size() != 0 &&
                   !(pending_bytes[0].hold && expected_fields.size() != 0)) begin
        next_beat = pending_bytes.pop_front();
        in_ch.valid         <= 1'b1;
        in_ch.char_byte     <= next_beat.char_byte;
        in_ch.end_of_record <= next_beat.eor;
        in_gap_left = gap_len(in_calm);
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // result side back-pressure
  int unsigned out_stall_left = 0;
  bit          out_calm       = 1'b0;

  always @(negedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if ($urandom_range(0, 199) == 0) out_calm = !out_calm;
      if (out_stall_left != 0) begin
        out_ch.ready <= 1'b0;
        out_stall_left--;
      end else begin
        out_ch.ready <= 1'b1;
        if ($urandom_range(0, 3) == 0) out_stall_left = gap_len(out_calm);
      end
    end
  end

  // monitor: predict on each byte beat, check each result beat
  field_result_t want;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_fired <= 1'b0;
    end else begin
      in_fired <= in_ch.valid && in_ch.ready;
      if (out_ch.valid && out_ch.ready) begin
        if (expected_fields.size() == 0) begin
          $display("%0t unexpected: expected none, actual %0d/%0d/%0d",
                   $time, out_ch.field_kind, out_ch.field_value, out_ch.record_done);
          fail_count++;
        end else begin
          want = expected_fields.pop_front();
          if ({out_ch.field_kind, out_ch.field_value, out_ch.record_done} !== want) begin
            $display("%0t mismatch: expected %0d/%0d/%0d actual %0d/%0d/%0d",
                     $time, want.kind, want.value, want.done,
                     out_ch.field_kind, out_ch.field_value, out_ch.record_done);
            fail_count++;
          end
        end
      end
      if (in_ch.valid && in_ch.ready) decode_byte(in_ch.char_byte, in_ch.end_of_record);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t watchdog: no beat for %0d cycles, %0d results outstanding",
                 $time, idle_cycles, expected_fields.size());
        $display("status: fail");
        $finish;
      end
    end
  end

  initial begin
    rst_n               = 1'b0;
    in_ch.valid         = 1'b0;
    in_ch.char_byte     = 8'd0;
    in_ch.end_of_record = 1'b0;
    out_ch.ready        = 1'b0;
    clear_record();

    // directed: byte extremes, colon closing, path hop, active flag exactly T
    queue_byte(8'd0, 1'b1, 1'b0);
    queue_byte(8'd255, 1'b1, 1'b0);
    queue_byte(COLON_BYTE, 1'b1, 1'b0);
    queue_byte(8'd57, 1'b0, 1'b0);
    queue_byte(MID_TOP, 1'b0, 1'b0);
    queue_byte(8'd128, 1'b1, 1'b0);
    queue_byte(COLON_BYTE, 1'b0, 1'b0);
    queue_byte(OFS_LOW, 1'b0, 1'b0);
    queue_byte(OFS_MID, 1'b0, 1'b0);
    queue_byte(8'd35, 1'b0, 1'b0);
    queue_byte(8'd126, 1'b0, 1'b0);
    queue_byte(8'd36, 1'b1, 1'b0);
    for (int i = 0; i < 8; i++) queue_byte(COLON_BYTE, 1'b0, 1'b0);
    queue_byte(CHAR_T, 1'b1, 1'b0);

    // random: mostly well-formed records, some short or overlong, some noise
    while (pending_bytes.size() < ITEM_TARGET) begin
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 60) begin
        queue_record(FIELD_COUNT, pending_bytes.size() < 30 || $urandom_range(0, 39) == 0);
      end else if (r < 72) begin
        queue_record($urandom_range(1, FIELD_COUNT - 1), 1'b0);
      end else if (r < 85) begin
        queue_record($urandom_range(FIELD_COUNT + 1, FIELD_COUNT + 3), 1'b0);
      end else begin
        int unsigned len;
        len = $urandom_range(1, 20);
        for (int unsigned i = 0; i < len; i++) begin
          queue_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0, 1'b0);
        end
      end
    end

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (pending_bytes.size() != 0 || in_ch.valid) @(posedge clk);
    while (expected_fields.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (expected_fields.size() != 0) begin
      $display("%0t missing: expected %0d more, first %0d/%0d, actual none",
               $time, expected_fields.size(), expected_fields[0].kind,
               expected_fields[0].value);
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

[files.f]
hdl/b92_pkg.sv
hdl/b92_ifs.sv
hdl/b92_field_dec.sv
hdl/b92_res_queue.sv
hdl/base92_record_field_decoder_core.sv
bench/base92_record_field_decoder_core_test.sv
